/* rtl/admv_pkg.sv */
// Shared types, constants and fixed-point map helpers for the ADC averaging block.
`default_nettype none
package admv_pkg;

  localparam int unsigned SampleW          = 16;
  localparam int unsigned MapW             = 32;
  localparam int unsigned ProdW            = 48;
  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned CfgDataW         = 32;
  localparam int unsigned WindowLenDefault = 16;
  localparam int unsigned QueueDepth       = 2;

  localparam logic                   EnableReset = 1'b1;
  localparam logic signed [MapW-1:0] GainReset   = 32'sh0100_0000;
  localparam logic signed [MapW-1:0] OffsetReset = 32'sh0000_0000;

  localparam logic signed [MapW-1:0] MapMax = 32'sh7fff_ffff;
  localparam logic signed [MapW-1:0] MapMin = 32'sh8000_0000;
  localparam logic signed [40:0]     SatMax = 41'sd2147483647;
  localparam logic signed [40:0]     SatMin = -41'sd2147483648;

  typedef enum logic [CfgIdxW-1:0] {
    RegEnable = 2'd0,
    RegGain   = 2'd1,
    RegOffset = 2'd2
  } admv_reg_e;

  typedef struct packed {
    logic signed [MapW-1:0] gain;
    logic signed [MapW-1:0] offset;
  } admv_map_cfg_t;

  // Signed Q8.24 gain times an unsigned integer sample; the exact product fits 48 bits.
  function automatic logic signed [ProdW-1:0] map_mul(logic signed [MapW-1:0] gain,
                                                       logic [SampleW-1:0] x);
    return ProdW'(gain) * ProdW'(signed'({1'b0, x}));
  endfunction

  // Drop 8 fraction bits with floor, add the Q16.16 offset and saturate to 32 bits.
  function automatic logic signed [MapW-1:0] map_finish(logic signed [ProdW-1:0] p,
                                                         logic signed [MapW-1:0] offset);
    logic signed [39:0] q;
    logic signed [40:0] r;
    q = 40'(p >>> 8);
    r = 41'(q) + 41'(offset);
    if (r > SatMax) begin
      return MapMax;
    end else if (r < SatMin) begin
      return MapMin;
    end else begin
      return $signed(r[MapW-1:0]);
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/admv_front.sv */
// Front end: channel gating, sample window ring buffer and running sum.
`default_nettype none
module admv_front #(
  parameter int unsigned WindowLen = 16,
  parameter int unsigned SumW      = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        cmd_i,
  input  wire logic [admv_pkg::SampleW-1:0] sample_i,
  input  wire logic                        enable_i,
  output logic      [admv_pkg::SampleW-1:0] raw_o,
  output logic      [SumW-1:0]             sum_o
);
  import admv_pkg::*;

  localparam int unsigned    SlotW    = (WindowLen > 1) ? $clog2(WindowLen) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WindowLen - 1);
  localparam logic [SumW-1:0]  SumMax   = SumW'(WindowLen * 65535);

  logic [SampleW-1:0] store_q [WindowLen];
  logic [WindowLen-1:0] valid_q;
  logic [SlotW-1:0]   slot_q, nxt_slot, rd_addr;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SampleW-1:0] rd_q, hold_q, old_val, raw;
  logic               hit_q, vld_q, wr;

  assign raw      = enable_i ? sample_i : '0;
  assign wr       = accept_i & cmd_i;
  assign nxt_slot = (slot_q == LastSlot) ? '0 : SlotW'(slot_q + 1'b1);
  assign rd_addr  = wr ? nxt_slot : slot_q;

  // The entry about to be overwritten is read ahead into a register; a window of one
  // entry reads back the sample it has just written.
  assign old_val = hit_q ? hold_q : (vld_q ? rd_q : '0);
  assign sum_d   = sum_q - SumW'(old_val) + SumW'(raw);

  assign raw_o = raw;
  assign sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      sum_q   <= '0;
      valid_q <= '0;
      hit_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      if (wr) begin
        slot_q          <= nxt_slot;
        sum_q           <= sum_d;
        valid_q[slot_q] <= 1'b1;
      end
      hit_q <= wr && (nxt_slot == slot_q);
      vld_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      store_q[slot_q] <= raw;
      hold_q          <= raw;
    end
    rd_q <= store_q[rd_addr];
  end

`ifndef SYNTHESIS
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) sum_q <= SumMax)
    else $error("running sum exceeds the window bound");
`endif

endmodule
`default_nettype wire

/* rtl/admv_queue.sv */
// Short FIFO that decouples the front end from the back end.
`default_nettype none
module admv_queue #(
  parameter int unsigned DataW = 37,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [DataW-1:0] data_i,
  input  wire logic             rd_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic      [DataW-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [DataW-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_i && full_o))
    else $error("queue written while full");
`endif

endmodule
`default_nettype wire

/* rtl/admv_back.sv */
// Back end: mean by reciprocal multiply, linear map pipeline and result register.
`default_nettype none
module admv_back #(
  parameter int unsigned WindowLen = 16,
  parameter int unsigned SumW      = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic                           cmd_i,
  input  wire logic        [admv_pkg::SampleW-1:0] raw_i,
  input  wire logic        [SumW-1:0]         sum_i,
  input  wire admv_pkg::admv_map_cfg_t        cfg_i,
  output logic                                take_o,
  input  wire logic                           pop_i,
  output logic                                empty_o,
  output logic             [admv_pkg::SampleW-1:0] raw_o,
  output logic             [admv_pkg::SampleW-1:0] mean_o,
  output logic signed      [admv_pkg::MapW-1:0]    raw_map_o,
  output logic signed      [admv_pkg::MapW-1:0]    mean_map_o
);
  import admv_pkg::*;

  // floor(sum / WindowLen) == (sum * ceil(2^Shift / WindowLen)) >> Shift for every sum
  // below 2^SumW when Shift = SumW + ceil(log2(WindowLen)).
  localparam int unsigned Log2N      = $clog2(WindowLen);
  localparam int unsigned DivShift   = SumW + Log2N;
  localparam int unsigned DivProdW   = 2 * SumW + 1;
  localparam longint unsigned DivMulFull =
    ((64'd1 << DivShift) + 64'(WindowLen) - 64'd1) / 64'(WindowLen);
  localparam logic [SumW:0] DivMul   = (SumW + 1)'(DivMulFull);

  logic                       v1_q, v2_q, v3_q, stall, mean_upd;
  logic                       cmd1_q;
  logic [SampleW-1:0]         raw1_q, raw2_q, raw3_q, mean2_q, mean3_q, mean_q;
  logic [SampleW-1:0]         mean_new, mean_sel;
  logic [DivProdW-1:0]        div_prod, div1_q;
  logic signed [ProdW-1:0]    rawp1_q, meanp2_q;
  logic signed [MapW-1:0]     rawmap2_q, rawmap3_q, meanmap3_q;

  assign stall    = v3_q & ~pop_i;
  assign take_o   = ~stall;
  assign empty_o  = ~v3_q;
  assign div_prod = DivProdW'(sum_i) * DivProdW'(DivMul);
  assign mean_new = div1_q[DivShift +: SampleW];
  assign mean_sel = cmd1_q ? mean_new : mean_q;
  assign mean_upd = ~stall & v1_q & cmd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      mean_q <= '0;
    end else begin
      if (!stall) begin
        v1_q <= valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
      if (mean_upd) begin
        mean_q <= mean_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      cmd1_q     <= cmd_i;
      raw1_q     <= raw_i;
      div1_q     <= div_prod;
      rawp1_q    <= map_mul(cfg_i.gain, raw_i);
      raw2_q     <= raw1_q;
      mean2_q    <= mean_sel;
      rawmap2_q  <= map_finish(rawp1_q, cfg_i.offset);
      meanp2_q   <= map_mul(cfg_i.gain, mean_sel);
      raw3_q     <= raw2_q;
      mean3_q    <= mean2_q;
      rawmap3_q  <= rawmap2_q;
      meanmap3_q <= map_finish(meanp2_q, cfg_i.offset);
    end
  end

  assign raw_o      = raw3_q;
  assign mean_o     = mean3_q;
  assign raw_map_o  = rawmap3_q;
  assign mean_map_o = meanmap3_q;

`ifndef SYNTHESIS
  a_mean_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(mean_q) |-> $past(mean_upd))
    else $error("mean register changed without a filter item");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q))
    else $error("result appeared without an item in the map stage");
`endif

endmodule
`default_nettype wire

/* rtl/adc_moving_average_with_linear_map_core.sv */
// ADC moving average with linear map. A result passes through the queue, reciprocal/map
// multiply, mean map multiply and mean map finish registers. Throughput: one sample per
// cycle while the queue has room, as the front end updates the running sum in the same
// cycle as the transfer; the back end pipeline stalls only while the result register is
// not taken. Reset (asynchronous, active low) clears the window valid bits, running sum,
// slot, mean and queue, and loads the configuration registers with their reset values.
`default_nettype none
module adc_moving_average_with_linear_map_core #(
  parameter int unsigned WindowLen = admv_pkg::WindowLenDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic        [admv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [admv_pkg::CfgDataW-1:0] cfg_data_i,
  // Sample side
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           cmd_i,
  input  wire logic        [admv_pkg::SampleW-1:0] sample_i,
  // Result side
  output logic                                empty,
  input  wire logic                           pop,
  output logic             [admv_pkg::SampleW-1:0] raw_value_o,
  output logic             [admv_pkg::SampleW-1:0] filtered_mean_o,
  output logic signed      [admv_pkg::MapW-1:0]    raw_mapped_o,
  output logic signed      [admv_pkg::MapW-1:0]    filtered_mapped_o
);
  import admv_pkg::*;

  // The running sum needs log2 of the window more bits than a sample and never wraps.
  localparam int unsigned SumW  = SampleW + $clog2(WindowLen);
  localparam int unsigned ItemW = 1 + SampleW + SumW;

  logic                   enable_q;
  admv_map_cfg_t          map_cfg_q;
  logic                   accept;
  logic [SampleW-1:0]     front_raw;
  logic [SumW-1:0]        front_sum;
  logic [ItemW-1:0]       item_in, item_out;
  logic                   q_valid, q_take, q_rd;

  // Configuration registers. They must be written only while the block is idle, so the
  // back end reads them directly; the user is bound, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q         <= EnableReset;
      map_cfg_q.gain   <= GainReset;
      map_cfg_q.offset <= OffsetReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEnable: enable_q         <= cfg_data_i[0];
        RegGain:   map_cfg_q.gain   <= $signed(cfg_data_i[MapW-1:0]);
        RegOffset: map_cfg_q.offset <= $signed(cfg_data_i[MapW-1:0]);
        default:   ;
      endcase
    end
  end

  // A sample transfer happens whenever push is high and the queue has room; if cmd_i is
  // set, the window updates in the same cycle; the item is queued with its new sum.
  assign accept = push & ~full;

  admv_front #(
    .WindowLen (WindowLen),
    .SumW      (SumW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .sample_i (sample_i),
    .enable_i (enable_q),
    .raw_o    (front_raw),
    .sum_o    (front_sum)
  );

  assign item_in = {cmd_i, front_raw, front_sum};

  admv_queue #(
    .DataW (ItemW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .data_i  (item_in),
    .rd_i    (q_rd),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (item_out)
  );

  assign q_rd = q_valid & q_take;

  // The back end holds its own copy of the mean, updated in item order, so report-only
  // items see the mean left by the filter items ahead of them.
  admv_back #(
    .WindowLen (WindowLen),
    .SumW      (SumW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .cmd_i      (item_out[ItemW-1]),
    .raw_i      (item_out[SumW +: SampleW]),
    .sum_i      (item_out[SumW-1:0]),
    .cfg_i      (map_cfg_q),
    .take_o     (q_take),
    .pop_i      (pop),
    .empty_o    (empty),
    .raw_o      (raw_value_o),
    .mean_o     (filtered_mean_o),
    .raw_map_o  (raw_mapped_o),
    .mean_map_o (filtered_mapped_o)
  );

endmodule
`default_nettype wire
